[rtl/core/serpent_pkg.sv]
package serpent_pkg;

   localparam int ROUND_KEY_WORDS = 132;
   localparam int NUM_ROUNDS = 32;

   typedef enum logic [1:0] {
      REQ_LOAD = 2'd0,
      REQ_ENC  = 2'd1,
      REQ_DEC  = 2'd2,
      REQ_NONE = 2'd3
   } req_code_type;

   typedef logic [3:0][31:0] blk_type;

   typedef logic [3:0] nib_type;

   localparam nib_type SBOX [8][16] = '{
      '{4'd3, 4'd8, 4'd15, 4'd1, 4'd10, 4'd6, 4'd5, 4'd11,
        4'd14, 4'd13, 4'd4, 4'd2, 4'd7, 4'd0, 4'd9, 4'd12},
      '{4'd15, 4'd12, 4'd2, 4'd7, 4'd9, 4'd0, 4'd5, 4'd10,
        4'd1, 4'd11, 4'd14, 4'd8, 4'd6, 4'd13, 4'd3, 4'd4},
      '{4'd8, 4'd6, 4'd7, 4'd9, 4'd3, 4'd12, 4'd10, 4'd15,
        4'd13, 4'd1, 4'd14, 4'd4, 4'd0, 4'd11, 4'd5, 4'd2},
      '{4'd0, 4'd15, 4'd11, 4'd8, 4'd12, 4'd9, 4'd6, 4'd3,
        4'd13, 4'd1, 4'd2, 4'd4, 4'd10, 4'd7, 4'd5, 4'd14},
      '{4'd1, 4'd15, 4'd8, 4'd3, 4'd12, 4'd0, 4'd11, 4'd6,
        4'd2, 4'd5, 4'd4, 4'd10, 4'd9, 4'd14, 4'd7, 4'd13},
      '{4'd15, 4'd5, 4'd2, 4'd11, 4'd4, 4'd10, 4'd9, 4'd12,
        4'd0, 4'd3, 4'd14, 4'd8, 4'd13, 4'd6, 4'd7, 4'd1},
      '{4'd7, 4'd2, 4'd12, 4'd5, 4'd8, 4'd4, 4'd6, 4'd11,
        4'd14, 4'd9, 4'd1, 4'd15, 4'd13, 4'd3, 4'd10, 4'd0},
      '{4'd1, 4'd13, 4'd15, 4'd0, 4'd14, 4'd8, 4'd2, 4'd11,
        4'd7, 4'd4, 4'd12, 4'd10, 4'd9, 4'd3, 4'd5, 4'd6}
   };

   // Look up one nibble in a forward or inverse S-box.
   function automatic nib_type sbox_nib(input int box, input nib_type x, input logic inv);
      nib_type y;
      y = SBOX[box][x];
      if (inv) begin
         y = '0;
         for (int v = 0; v < 16; v++) begin
            if (SBOX[box][v] == x) y = nib_type'(v);
         end
      end
      return y;
   endfunction

   // Bitsliced S-box: bit i of the four words forms one nibble, word 0 its LSB.
   function automatic blk_type sbox_blk(input int box, input blk_type w, input logic inv);
      blk_type r;
      nib_type n;
      nib_type y;
      for (int i = 0; i < 32; i++) begin
         n = {w[3][i], w[2][i], w[1][i], w[0][i]};
         y = sbox_nib(box, n, inv);
         for (int j = 0; j < 4; j++) r[j][i] = y[j];
      end
      return r;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic blk_type lin_fwd(input blk_type w);
      blk_type t;
      t = w;
      t[0] = rotl(t[0], 13);
      t[2] = rotl(t[2], 3);
      t[1] = t[1] ^ t[0] ^ t[2];
      t[3] = t[3] ^ t[2] ^ (t[0] << 3);
      t[1] = rotl(t[1], 1);
      t[3] = rotl(t[3], 7);
      t[0] = t[0] ^ t[1] ^ t[3];
      t[2] = t[2] ^ t[3] ^ (t[1] << 7);
      t[0] = rotl(t[0], 5);
      t[2] = rotl(t[2], 22);
      return t;
   endfunction

   function automatic blk_type lin_inv(input blk_type w);
      blk_type t;
      t = w;
      t[2] = rotl(t[2], 10);
      t[0] = rotl(t[0], 27);
      t[2] = t[2] ^ t[3] ^ (t[1] << 7);
      t[0] = t[0] ^ t[1] ^ t[3];
      t[3] = rotl(t[3], 25);
      t[1] = rotl(t[1], 31);
      t[3] = t[3] ^ t[2] ^ (t[0] << 3);
      t[1] = t[1] ^ t[0] ^ t[2];
      t[2] = rotl(t[2], 29);
      t[0] = rotl(t[0], 19);
      return t;
   endfunction

endpackage

[rtl/core/serpent_block_cipher.sv]
// A block beat goes from the input register through 32 round stages, one
// round each, to its result beat; one block per cycle unless output stalls.
// A key-load beat is held off until the round pipeline and output are empty.
// Reset (synchronous, active high) clears all valid bits; round keys are
// not cleared and read as undefined until written.
module serpent_block_cipher
   import serpent_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_key_index,
   input  logic [31:0] req_key_word,
   input  logic [63:0] req_block_lo,
   input  logic [63:0] req_block_hi,
   input  logic        req_last_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_lo,
   output logic [63:0] rsp_out_hi,
   output logic        rsp_out_last
);

   logic [31:0] rk_ff [ROUND_KEY_WORDS];

   logic    valid_ff [NUM_ROUNDS+1];
   logic    valid_in [NUM_ROUNDS+1];
   logic    dec_ff   [NUM_ROUNDS+1];
   logic    last_ff  [NUM_ROUNDS+1];
   blk_type data_ff  [NUM_ROUNDS+1];
   blk_type data_in  [NUM_ROUNDS+1];

   logic advance;
   logic busy;
   logic is_block;
   logic is_load;
   logic req_accept;

   // Pipeline moves as a whole unless the output beat is stalled.
   assign advance = !valid_ff[NUM_ROUNDS] || !rsp_stall;

   always_comb begin
      busy = 1'b0;
      for (int i = 0; i <= NUM_ROUNDS; i++) busy = busy | valid_ff[i];
   end

   assign is_load  = (req_type == REQ_LOAD);
   assign is_block = (req_type == REQ_ENC) || (req_type == REQ_DEC);
   assign req_stall = !advance || (is_load && busy);
   assign req_accept = req_valid && !req_stall;

   // Key store write.
   always_ff @(posedge clock) begin
      if (req_accept && is_load && (req_key_index < 8'(ROUND_KEY_WORDS))) begin
         rk_ff[req_key_index] <= req_key_word;
      end
   end

   // Input stage.
   assign valid_in[0] = req_accept && is_block;
   assign data_in[0]  = {req_block_hi, req_block_lo};

   // Round stages: stage i does encryption round i or decryption round 31-i.
   for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_round
      blk_type ke;
      blk_type kd;
      blk_type kl;
      assign ke = {rk_ff[4*i+3], rk_ff[4*i+2], rk_ff[4*i+1], rk_ff[4*i]};
      assign kd = {rk_ff[4*(31-i)+3], rk_ff[4*(31-i)+2],
                   rk_ff[4*(31-i)+1], rk_ff[4*(31-i)]};
      assign kl = {rk_ff[131], rk_ff[130], rk_ff[129], rk_ff[128]};

      always_comb begin
         blk_type t;
         t = data_ff[i];
         if (!dec_ff[i]) begin
            t = sbox_blk(i % 8, t ^ ke, 1'b0);
            if (i < NUM_ROUNDS - 1) t = lin_fwd(t);
            else t = t ^ kl;
         end else begin
            if (i == 0) t = t ^ kl;
            else t = lin_inv(t);
            t = sbox_blk((31 - i) % 8, t, 1'b1) ^ kd;
         end
         data_in[i+1] = t;
      end
      assign valid_in[i+1] = valid_ff[i];
   end

   // Stage registers.
   for (genvar s = 0; s <= NUM_ROUNDS; s++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_in[s];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            data_ff[s] <= data_in[s];
            if (s == 0) begin
               dec_ff[s]  <= (req_type == REQ_DEC);
               last_ff[s] <= req_last_block;
            end else begin
               dec_ff[s]  <= dec_ff[(s == 0) ? 0 : s-1];
               last_ff[s] <= last_ff[(s == 0) ? 0 : s-1];
            end
         end
      end
   end

   assign rsp_valid    = valid_ff[NUM_ROUNDS];
   assign rsp_out_lo   = {data_ff[NUM_ROUNDS][1], data_ff[NUM_ROUNDS][0]};
   assign rsp_out_hi   = {data_ff[NUM_ROUNDS][3], data_ff[NUM_ROUNDS][2]};
   assign rsp_out_last = last_ff[NUM_ROUNDS];

`ifndef SYNTHESIS
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_load) |-> !busy)
      else $error("key load accepted with blocks in flight");
   a_no_stall_move: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(valid_ff[0]))
      else $error("pipeline moved under output stall");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (advance && valid_ff[NUM_ROUNDS-1]) |=> rsp_valid)
      else $error("block lost in last stage");
`endif

endmodule

[test/tb_top.sv]
module tb_top
   import serpent_pkg::*;
;

   typedef logic [3:0][31:0] quad_type;

   typedef struct {
      logic [63:0] lo;
      logic [63:0] hi;
      logic        last;
   } cipher_out_type;

   typedef struct {
      req_code_type kind;
      logic [7:0]   idx;
      logic [31:0]  word;
      logic [63:0]  lo;
      logic [63:0]  hi;
      logic         last;
   } beat_type;

   // Forward Serpent S-boxes, one row per box.
   localparam logic [3:0] FWD_SUB [8][16] = '{
      '{3, 8, 15, 1, 10, 6, 5, 11, 14, 13, 4, 2, 7, 0, 9, 12},
      '{15, 12, 2, 7, 9, 0, 5, 10, 1, 11, 14, 8, 6, 13, 3, 4},
      '{8, 6, 7, 9, 3, 12, 10, 15, 13, 1, 14, 4, 0, 11, 5, 2},
      '{0, 15, 11, 8, 12, 9, 6, 3, 13, 1, 2, 4, 10, 7, 5, 14},
      '{1, 15, 8, 3, 12, 0, 11, 6, 2, 5, 4, 10, 9, 14, 7, 13},
      '{15, 5, 2, 11, 4, 10, 9, 12, 0, 3, 14, 8, 13, 6, 7, 1},
      '{7, 2, 12, 5, 8, 4, 6, 11, 14, 9, 1, 15, 13, 3, 10, 0},
      '{1, 13, 15, 0, 14, 8, 2, 11, 7, 4, 12, 10, 9, 3, 5, 6}
   };

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_ITEMS = 800;
   localparam int HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_type;
   logic [7:0]  req_key_index;
   logic [31:0] req_key_word;
   logic [63:0] req_block_lo;
   logic [63:0] req_block_hi;
   logic        req_last_block;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_out_lo;
   logic [63:0] rsp_out_hi;
   logic        rsp_out_last;

   logic [3:0]  inv_sub [8][16];
   logic [31:0] key_store [ROUND_KEY_WORDS];
   cipher_out_type expected_blocks [$];
   int          mismatches = 0;
   int          blocks_seen = 0;
   int          blocks_sent = 0;
   int          keys_loaded = 0;
   int          ignored_beats = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          quiet_cycles = 0;
   logic [63:0] last_ct_lo;
   logic [63:0] last_ct_hi;

   serpent_block_cipher uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_key_index  (req_key_index),
      .req_key_word   (req_key_word),
      .req_block_lo   (req_block_lo),
      .req_block_hi   (req_block_hi),
      .req_last_block (req_last_block),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_lo     (rsp_out_lo),
      .rsp_out_hi     (rsp_out_hi),
      .rsp_out_last   (rsp_out_last)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] rol(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic quad_type mix_key(input quad_type w, input int rnd);
      quad_type r;
      r = w;
      for (int j = 0; j < 4; j++) r[j] = r[j] ^ key_store[rnd * 4 + j];
      return r;
   endfunction

   // Bitsliced substitution: bit i of the four words is one nibble, word 0 its LSB.
   function automatic quad_type substitute(input quad_type w, input int box, input bit inv);
      quad_type   r;
      logic [3:0] n;
      logic [3:0] y;
      for (int i = 0; i < 32; i++) begin
         n = {w[3][i], w[2][i], w[1][i], w[0][i]};
         y = inv ? inv_sub[box][n] : FWD_SUB[box][n];
         for (int j = 0; j < 4; j++) r[j][i] = y[j];
      end
      return r;
   endfunction

   function automatic quad_type diffuse(input quad_type w);
      quad_type t;
      t = w;
      t[0] = rol(t[0], 13);
      t[2] = rol(t[2], 3);
      t[1] = t[1] ^ t[0] ^ t[2];
      t[3] = t[3] ^ t[2] ^ (t[0] << 3);
      t[1] = rol(t[1], 1);
      t[3] = rol(t[3], 7);
      t[0] = t[0] ^ t[1] ^ t[3];
      t[2] = t[2] ^ t[3] ^ (t[1] << 7);
      t[0] = rol(t[0], 5);
      t[2] = rol(t[2], 22);
      return t;
   endfunction

   function automatic quad_type undiffuse(input quad_type w);
      quad_type t;
      t = w;
      t[2] = rol(t[2], 32 - 22);
      t[0] = rol(t[0], 32 - 5);
      t[2] = t[2] ^ t[3] ^ (t[1] << 7);
      t[0] = t[0] ^ t[1] ^ t[3];
      t[3] = rol(t[3], 32 - 7);
      t[1] = rol(t[1], 32 - 1);
      t[3] = t[3] ^ t[2] ^ (t[0] << 3);
      t[1] = t[1] ^ t[0] ^ t[2];
      t[2] = rol(t[2], 32 - 3);
      t[0] = rol(t[0], 32 - 13);
      return t;
   endfunction

   function automatic quad_type serpent_encrypt(input quad_type w);
      quad_type t;
      t = w;
      for (int r = 0; r < NUM_ROUNDS; r++) begin
         t = substitute(mix_key(t, r), r % 8, 1'b0);
         if (r < NUM_ROUNDS - 1) t = diffuse(t);
         else t = mix_key(t, NUM_ROUNDS);
      end
      return t;
   endfunction

   function automatic quad_type serpent_decrypt(input quad_type w);
      quad_type t;
      t = mix_key(w, NUM_ROUNDS);
      for (int r = NUM_ROUNDS - 1; r >= 0; r--) begin
         if (r < NUM_ROUNDS - 1) t = undiffuse(t);
         t = mix_key(substitute(t, r % 8, 1'b1), r);
      end
      return t;
   endfunction

   // Update the key store or queue the expected block for one accepted beat.
   task automatic predict_beat(input beat_type b);
      quad_type       q;
      cipher_out_type e;
      case (b.kind)
         REQ_LOAD: begin
            if (b.idx < ROUND_KEY_WORDS) begin
               key_store[b.idx] = b.word;
               keys_loaded++;
            end else begin
               ignored_beats++;
            end
         end
         REQ_ENC, REQ_DEC: begin
            q = {b.hi, b.lo};
            q = (b.kind == REQ_ENC) ? serpent_encrypt(q) : serpent_decrypt(q);
            e.lo = q[1:0];
            e.hi = q[3:2];
            e.last = b.last;
            expected_blocks.push_back(e);
            blocks_sent++;
            if (b.kind == REQ_ENC) begin
               last_ct_lo = e.lo;
               last_ct_hi = e.hi;
            end
         end
         default: ignored_beats++;
      endcase
   endtask

   // Offer one beat after a random gap and wait until it is accepted.
   task automatic send_beat(input beat_type b);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 200) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= b.kind;
      req_key_index  <= b.idx;
      req_key_word   <= b.word;
      req_block_lo   <= b.lo;
      req_block_hi   <= b.hi;
      req_last_block <= b.last;
      do @(posedge clock); while (req_stall);
      predict_beat(b);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s at block %0d: got %h, expected %h",
               what, blocks_seen, got, want);
      mismatches++;
   endtask

   // Result side: check each beat, then pick the stall for the next cycle.
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      cipher_out_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_out_lo, 64'h0);
         end else begin
            e = expected_blocks.pop_front();
            if (rsp_out_lo !== e.lo) report_mismatch("out_lo", rsp_out_lo, e.lo);
            if (rsp_out_hi !== e.hi) report_mismatch("out_hi", rsp_out_hi, e.hi);
            if (rsp_out_last !== e.last)
               report_mismatch("out_last", 64'(rsp_out_last), 64'(e.last));
         end
         blocks_seen++;
         // Once, hold the output off long enough to back the pipeline up.
         if (!hold_done && blocks_seen == 60) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog on cycles with no beat on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", expected_blocks.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Directed beats: extremes, key reloads, ignored requests and unused fields.
   localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ALT  = 64'hAAAA_AAAA_AAAA_AAAA;
   beat_type directed_rows [17] = '{
      '{REQ_ENC,  8'd0,   32'h0,        64'h0, 64'h0, 1'b0},
      '{REQ_ENC,  8'd0,   32'h0,        ONES,  ONES,  1'b1},
      '{REQ_DEC,  8'd0,   32'h0,        64'h0, 64'h0, 1'b1},
      '{REQ_DEC,  8'd0,   32'h0,        ONES,  ONES,  1'b0},
      '{REQ_ENC,  8'hFF,  32'hFFFFFFFF, ALT,   ~ALT,  1'b0},
      '{REQ_DEC,  8'hFF,  32'hFFFFFFFF, ~ALT,  ALT,   1'b1},
      '{REQ_LOAD, 8'd131, 32'hFFFFFFFF, ONES,  ONES,  1'b1},
      '{REQ_LOAD, 8'd0,   32'h0,        ALT,   ALT,   1'b0},
      '{REQ_ENC,  8'd0,   32'h0,        64'h1, 64'h0, 1'b0},
      '{REQ_LOAD, 8'd132, 32'h12345678, 64'h0, 64'h0, 1'b0},
      '{REQ_LOAD, 8'hFF,  32'hFFFFFFFF, 64'h0, 64'h0, 1'b1},
      '{REQ_NONE, 8'hFF,  32'hFFFFFFFF, ONES,  ONES,  1'b1},
      '{REQ_NONE, 8'd5,   32'h0,        64'h0, 64'h0, 1'b0},
      '{REQ_ENC,  8'd0,   32'h0,        64'h0, ONES,  1'b1},
      '{REQ_DEC,  8'd0,   32'h0,        ONES,  64'h0, 1'b0},
      '{REQ_LOAD, 8'd64,  32'h80000001, 64'h0, 64'h0, 1'b0},
      '{REQ_DEC,  8'd0,   32'h0,        64'h8000_0000_0000_0000, 64'h1, 1'b1}
   };

   // Main stimulus sequence.
   initial begin
      beat_type b;
      int       counted;
      int       pick;
      for (int bx = 0; bx < 8; bx++)
         for (int v = 0; v < 16; v++) inv_sub[bx][FWD_SUB[bx][v]] = v[3:0];
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_type       <= REQ_NONE;
      req_key_index  <= '0;
      req_key_word   <= '0;
      req_block_lo   <= '0;
      req_block_hi   <= '0;
      req_last_block <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Every round-key word is written before the first block.
      for (int k = 0; k < ROUND_KEY_WORDS; k++) begin
         b = '{REQ_LOAD, k[7:0], $urandom, {$urandom, $urandom}, 64'h0, 1'b0};
         send_beat(b);
      end
      foreach (directed_rows[i]) send_beat(directed_rows[i]);

      // Random traffic in four idling phases; the long output hold lands in the first.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         case (counted * 4 / RANDOM_ITEMS)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 86; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 86; end
            default: begin idle_pct = 31; stall_pct = 31; end
         endcase
         pick = $urandom_range(99);
         b.idx  = 8'($urandom);
         b.word = $urandom;
         b.lo   = {$urandom, $urandom};
         b.hi   = {$urandom, $urandom};
         b.last = 1'($urandom);
         if (pick < 6) begin
            b.kind = REQ_LOAD;
            b.idx  = 8'($urandom_range(0, 255));
         end else if (pick < 9) begin
            b.kind = REQ_NONE;
         end else if (pick < 15) begin
            // Decrypt the latest ciphertext to exercise the round trip.
            b.kind = REQ_DEC;
            b.lo   = last_ct_lo;
            b.hi   = last_ct_hi;
         end else begin
            b.kind = (pick < 57) ? REQ_ENC : REQ_DEC;
         end
         send_beat(b);
         counted++;
      end
      req_valid <= 1'b0;

      // Drain; the watchdog catches a result that never comes.
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_blocks.size() != 0) mismatches++;

      $display("Covered %0d blocks sent, %0d checked, %0d key words loaded, %0d ignored beats,",
               blocks_sent, blocks_seen, keys_loaded, ignored_beats);
      $display("with idle and stall phases and one long output hold; %0d mismatches.",
               mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[serpent_block_cipher.f]
rtl/core/serpent_pkg.sv
rtl/core/serpent_block_cipher.sv
test/tb_top.sv
